// ----- sv/fpm_pkg.sv -----
// Shared types and constants for the prefix-max binary indexed tree.
// Used by fpm_front, fpm_back and fenwick_prefix_max_unit; depends on nothing.
`default_nettype none

package fpm_pkg;

	localparam int POS_W = 11;
	localparam int VAL_W = 32;
	// Wide enough to hold twice the largest supported tree size.
	localparam int IDX_W = 22;

	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef struct packed {
		logic             op;
		logic [IDX_W-1:0] bound;
		logic [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic cmd_pop;
		logic init_busy;
	} back_stat_t;

endpackage

`default_nettype wire

// ----- sv/fpm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used by fpm_back for the tree node store.
`default_nettype none

module fpm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/fpm_front.sv -----
// Front end: accepts words, drops updates no node covers, clamps query bounds,
// and holds accepted commands in a two-entry queue. Depends on fpm_pkg.
`default_nettype none

module fpm_front #(
	parameter int TREE_SIZE = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output      logic                      full,
	input  wire logic                      operation,
	input  wire logic [fpm_pkg::POS_W-1:0] position,
	input  wire logic [fpm_pkg::VAL_W-1:0] new_value,
	output      logic                      cmd_valid,
	output      fpm_pkg::cmd_t             cmd,
	input  wire fpm_pkg::back_stat_t       stat
);

	import fpm_pkg::*;

	logic [IDX_W-1:0] pos_ext;
	logic             pos_over;
	logic             keep;
	logic             accept;
	logic             enq;
	logic             deq;
	cmd_t             new_cmd;
	cmd_t             fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;

	assign pos_ext  = IDX_W'(position);
	assign pos_over = pos_ext > IDX_W'(TREE_SIZE);

	// Updates at position zero or past the last node touch nothing.
	assign keep = (operation == OP_QUERY) || ((pos_ext != '0) && !pos_over);

	assign full   = stat.init_busy || (cnt_q == 2'd2);
	assign accept = push && !full;
	assign enq    = accept && keep;
	assign deq    = stat.cmd_pop;

	always_comb begin
		new_cmd.op    = operation;
		new_cmd.bound = pos_over ? IDX_W'(TREE_SIZE) : pos_ext;
		new_cmd.value = new_value;
	end

	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (enq) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (deq) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (enq && !deq) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (deq && !enq) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("command queue count out of range");

	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		enq && !deq |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("enqueued command did not raise the count");

	a_upd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && (cmd.op == OP_UPDATE) |->
			(cmd.bound != '0) && (cmd.bound <= IDX_W'(TREE_SIZE)))
		else $error("queued update targets no tree node");

endmodule

`default_nettype wire

// ----- sv/fpm_back.sv -----
// Back end: clears the node RAM after reset, then walks the tree one node per
// cycle for each command and holds one result. Depends on fpm_pkg and fpm_ram.
`default_nettype none

module fpm_back #(
	parameter int TREE_SIZE = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_valid,
	input  wire fpm_pkg::cmd_t             cmd,
	output      fpm_pkg::back_stat_t       stat,
	output      logic                      empty,
	input  wire logic                      pop,
	output      logic [fpm_pkg::VAL_W-1:0] prefix_max
);

	import fpm_pkg::*;

	localparam int AW = $clog2(TREE_SIZE);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [AW-1:0]    clr_q;
	logic             op_q;
	logic [IDX_W-1:0] idx_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] best_q;
	logic             vld_s1;
	logic [AW-1:0]    addr_s1;
	logic             out_vld_q;
	logic [VAL_W-1:0] prefix_max_q;

	logic             in_rng;
	logic [IDX_W-1:0] step;
	logic [IDX_W-1:0] idx_nxt;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [VAL_W-1:0] rd_data;
	logic             upd_hit;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             out_free;
	logic             ld_out;

	// Queries walk down by the lowest set bit to zero; updates walk up past the top.
	assign in_rng  = (op_q == OP_QUERY) ? (idx_q != '0) : (idx_q <= IDX_W'(TREE_SIZE));
	assign step    = idx_q & (~idx_q + IDX_W'(1));
	assign idx_nxt = (op_q == OP_QUERY) ? (idx_q - step) : (idx_q + step);

	assign rd_en   = (state_q == ST_WALK) && in_rng;
	assign rd_addr = AW'(idx_q - IDX_W'(1));

	// The node read last cycle is now on rd_data; raise it if the new value is larger.
	assign upd_hit = vld_s1 && (op_q == OP_UPDATE) && (rd_data < val_q);
	assign wr_en   = (state_q == ST_CLEAR) || upd_hit;
	assign wr_addr = (state_q == ST_CLEAR) ? clr_q : addr_s1;
	assign wr_data = (state_q == ST_CLEAR) ? '0 : val_q;

	assign out_free = !out_vld_q || pop;
	assign ld_out   = (state_q == ST_DRAIN) && (op_q == OP_QUERY) && out_free;

	assign stat.cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign stat.init_busy = state_q == ST_CLEAR;

	assign empty      = !out_vld_q;
	assign prefix_max = prefix_max_q;

	fpm_ram #(
		.WIDTH(VAL_W),
		.DEPTH(TREE_SIZE)
	) u_nodes (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			op_q         <= OP_QUERY;
			idx_q        <= '0;
			val_q        <= '0;
			best_q       <= '0;
			vld_s1       <= 1'b0;
			addr_s1      <= '0;
			out_vld_q    <= 1'b0;
			prefix_max_q <= '0;
		end else begin
			vld_s1  <= rd_en;
			addr_s1 <= rd_addr;

			if (vld_s1 && (op_q == OP_QUERY) && (rd_data > best_q)) begin
				best_q <= rd_data;
			end

			if (ld_out) begin
				out_vld_q    <= 1'b1;
				prefix_max_q <= best_q;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TREE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						op_q    <= cmd.op;
						idx_q   <= cmd.bound;
						val_q   <= cmd.value;
						best_q  <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (in_rng) begin
						idx_q <= idx_nxt;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if ((op_q == OP_UPDATE) || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("node read and write collide");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stat.init_busy |-> !stat.cmd_pop)
		else $error("command taken during clearing pass");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out && out_vld_q |-> pop)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- sv/fenwick_prefix_max_unit.sv -----
// Channel   Handshake     Fields
// input     push / full   operation, position, new_value
// result    empty / pop   prefix_max (one word per query, none per update)
//
// A query walks one node per set bit of its bound; an update walks one node per
// upward step until the index passes TREE_SIZE.
// The walker reads one node per cycle from the node RAM's single read port.
// After reset a clearing pass writes every node to zero, with full held high.
// A two-word command queue lets input continue while a result waits on pop;
// updates that touch no node are accepted and dropped.
// Top level of the prefix-max binary indexed tree. Depends on fpm_pkg,
// fpm_front, fpm_back and fpm_ram.
`default_nettype none

module fenwick_prefix_max_unit #(
	parameter int TREE_SIZE = 1024
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output      logic                      full,
	input  wire logic                      operation,
	input  wire logic [fpm_pkg::POS_W-1:0] position,
	input  wire logic [fpm_pkg::VAL_W-1:0] new_value,
	output      logic                      empty,
	input  wire logic                      pop,
	output      logic [fpm_pkg::VAL_W-1:0] prefix_max
);

	import fpm_pkg::*;

	logic       cmd_valid;
	cmd_t       cmd;
	back_stat_t stat;

	fpm_front #(
		.TREE_SIZE(TREE_SIZE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.position (position),
		.new_value(new_value),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.stat     (stat)
	);

	fpm_back #(
		.TREE_SIZE(TREE_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.stat      (stat),
		.empty     (empty),
		.pop       (pop),
		.prefix_max(prefix_max)
	);

endmodule

`default_nettype wire

// ----- dv/fenwick_prefix_max_unit_tb.sv -----
// Self-checking testbench for the prefix-max binary indexed tree unit.
// Needs fpm_pkg and fenwick_prefix_max_unit; a local tree predicts every query result.
`timescale 1ns / 100ps

module fenwick_prefix_max_unit_tb;

	import fpm_pkg::*;

	localparam int TREE_SIZE = 1024;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic             op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} tree_word_t;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	logic             operation;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] new_value;
	logic             empty;
	logic             pop;
	logic [VAL_W-1:0] prefix_max;

	fenwick_prefix_max_unit #(
		.TREE_SIZE(TREE_SIZE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.position  (position),
		.new_value (new_value),
		.empty     (empty),
		.pop       (pop),
		.prefix_max(prefix_max)
	);

	// Local copy of the tree, indexed from 1 like the block's nodes.
	logic [VAL_W-1:0] node_max [1:TREE_SIZE];
	tree_word_t       pending_words[$];
	logic [VAL_W-1:0] max_expected[$];

	int unsigned sender_idle_pct;
	int unsigned receiver_idle_pct;
	int unsigned offered_cnt;
	int unsigned accepted_cnt;
	int unsigned query_cnt;
	int unsigned checked_cnt;
	int unsigned full_stall_cnt;
	int unsigned error_cnt;
	int unsigned holds_asked;
	int unsigned holds_granted;
	int unsigned hold_left;
	int unsigned value_step;

	function automatic logic [VAL_W-1:0] range_max(int unsigned bound);
		logic [VAL_W-1:0] best;
		best = '0;
		if (bound > TREE_SIZE)
			bound = TREE_SIZE;
		while (bound != 0) begin
			if (node_max[bound] > best)
				best = node_max[bound];
			bound = bound - (bound & (~bound + 1));
		end
		return best;
	endfunction

	function automatic void raise_node(int unsigned idx, logic [VAL_W-1:0] value);
		if (idx == 0 || idx > TREE_SIZE)
			return;
		while (idx <= TREE_SIZE) begin
			if (node_max[idx] < value)
				node_max[idx] = value;
			idx = idx + (idx & (~idx + 1));
		end
	endfunction

	task automatic add_word(logic op, int unsigned pos, logic [VAL_W-1:0] value);
		tree_word_t w;
		w.op = op;
		w.pos = pos[POS_W-1:0];
		w.value = value;
		pending_words = {pending_words, w};
	endtask

	// Update values climb with the update count so later writes keep moving the
	// maxima instead of the tree saturating early; a share stay small.
	task automatic add_random_words(int unsigned count);
		int unsigned pick;
		int unsigned pos;
		logic [VAL_W-1:0] value;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			if (pick < 4)
				pos = 0;
			else if (pick < 10)
				pos = $urandom_range(TREE_SIZE + 1, (1 << POS_W) - 1);
			else if (pick < 20)
				pos = $urandom_range(1, 16);
			else
				pos = $urandom_range(1, TREE_SIZE);
			if ($urandom_range(0, 1) == 0) begin
				add_word(OP_QUERY, pos, $urandom);
			end else begin
				value_step++;
				if ($urandom_range(0, 99) < 12)
					value = $urandom_range(0, 255);
				else
					value = (VAL_W'(value_step) << 22) + $urandom_range(0, 32'h003F_FFFF);
				add_word(OP_UPDATE, pos, value);
			end
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || push || max_expected.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		operation = OP_QUERY;
		position = '0;
		new_value = '0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver: pops at random, and serves each hold-off request by keeping
	// pop low for a long stretch.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else if (holds_granted < holds_asked) begin
			holds_granted = holds_granted + 1;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
		end
	end

	// Sender: an offered word stays on the ports until it is taken.
	always @(negedge clk) begin
		tree_word_t w;
		if (push && accepted_cnt != offered_cnt) begin
			push <= 1'b1;
		end else if (pending_words.size() != 0 &&
				$urandom_range(0, 99) >= sender_idle_pct) begin
			w = pending_words.pop_front();
			offered_cnt = offered_cnt + 1;
			push <= 1'b1;
			operation <= w.op;
			position <= w.pos;
			new_value <= w.value;
		end else begin
			push <= 1'b0;
		end
	end

	// Results are checked before the same edge's input is folded into the tree.
	always @(posedge clk) begin
		logic [VAL_W-1:0] want;
		if (arst_n && pop && !empty) begin
			checked_cnt = checked_cnt + 1;
			if (max_expected.size() == 0) begin
				error_cnt = error_cnt + 1;
				if (error_cnt <= MAX_REPORTS)
					$display("%0t: result 0x%08h arrived with none expected", $time, prefix_max);
			end else begin
				want = max_expected.pop_front();
				if (prefix_max !== want) begin
					error_cnt = error_cnt + 1;
					if (error_cnt <= MAX_REPORTS)
						$display("%0t: prefix_max expected 0x%08h, got 0x%08h",
							$time, want, prefix_max);
				end
			end
		end
		if (arst_n && push && full)
			full_stall_cnt = full_stall_cnt + 1;
		if (arst_n && push && !full) begin
			accepted_cnt = accepted_cnt + 1;
			if (operation == OP_QUERY) begin
				query_cnt = query_cnt + 1;
				max_expected = {max_expected, range_max(32'(position))};
			end else begin
				raise_node(32'(position), new_value);
			end
		end
	end

	initial begin
		for (int i = 1; i <= TREE_SIZE; i++)
			node_max[i] = '0;
		sender_idle_pct = 25;
		receiver_idle_pct = 60;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty tree, ignored updates at zero and past the end, then a few
		// writes whose coverage of the query ranges is easy to follow.
		add_word(OP_QUERY, 0, 32'hFFFF_FFFF);
		add_word(OP_QUERY, 1, '0);
		add_word(OP_QUERY, TREE_SIZE, '0);
		add_word(OP_QUERY, 2047, '0);
		add_word(OP_UPDATE, 0, 32'hFFFF_FFFF);
		add_word(OP_UPDATE, TREE_SIZE + 1, 32'hFFFF_FFFF);
		add_word(OP_UPDATE, 2047, 32'hFFFF_FFFF);
		add_word(OP_QUERY, 2047, '0);
		add_word(OP_UPDATE, TREE_SIZE, 5);
		add_word(OP_QUERY, TREE_SIZE - 1, '0);
		add_word(OP_QUERY, TREE_SIZE, '0);
		add_word(OP_QUERY, 1500, '0);
		add_word(OP_UPDATE, 1, 0);
		add_word(OP_UPDATE, 512, 100);
		add_word(OP_UPDATE, 513, 50);
		add_word(OP_QUERY, 511, '0);
		add_word(OP_QUERY, 513, '0);
		add_word(OP_UPDATE, TREE_SIZE - 1, 32'hAAAA_AAAA);
		add_word(OP_UPDATE, 700, 32'h5555_5555);
		add_word(OP_UPDATE, 1, 7);
		add_word(OP_QUERY, 1, '0);
		add_word(OP_QUERY, 0, '0);
		add_word(OP_QUERY, 2047, 32'hFFFF_FFFF);
		wait_drained();

		add_random_words(280);
		wait_drained();

		sender_idle_pct = 60;
		receiver_idle_pct = 25;
		add_random_words(280);
		wait_drained();

		// Full-rate traffic against a stalled receiver backs the block up.
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		holds_asked = holds_asked + 1;
		add_random_words(290);
		add_word(OP_UPDATE, 3, 32'hFFFF_FFFF);
		add_word(OP_QUERY, 2, '0);
		add_word(OP_QUERY, 3, '0);
		add_word(OP_QUERY, 2047, '0);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (max_expected.size() != 0)
			error_cnt = error_cnt + max_expected.size();

		$display("Summary: %0d words taken (%0d queries), %0d prefix maxima checked,",
			accepted_cnt, query_cnt, checked_cnt);
		$display("         %0d cycles with push held off by full, %0d mismatches.",
			full_stall_cnt, error_cnt);
		if (error_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
